>>> design/pwmcds_pkg.sv
// ----------------------------------------------------------------------------
// PWM channel divider settings package
// Shared types and constants for the divider settings core and its
// bit-serial divider.
// ----------------------------------------------------------------------------
package pwmcds_pkg;

    // Divider datapath widths.
    localparam int DIV_W     = 40;
    localparam int DIVISOR_W = 32;
    localparam int STEP_W    = 6;

    // Quotient bits needed by each division of the sequence.
    localparam int F_STEPS    = 30;
    localparam int D_STEPS    = 25;
    localparam int Q_STEPS    = 40;
    localparam int P_STEPS    = 30;
    localparam int DUTY_STEPS = 38;

    // Clock and field limits.
    localparam logic [24:0] BASE_HZ        = 25'd27000000;
    localparam logic [29:0] NS_PER_S       = 30'd1000000000;
    localparam logic [7:0]  OUT_DIV_MAX    = 8'hff;
    localparam logic [3:0]  SRC_DIV_MAX    = 4'hf;
    localparam int          SRC_MSB_OFFSET = 8;

    // Operation codes.
    localparam logic OP_APPLY = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INV_POL  = 2'd1,
        STATUS_ZERO_PER = 2'd2
    } status_t;

    // Command from the sequencer to the divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

endpackage

>>> design/pwmcds_div.sv
// ----------------------------------------------------------------------------
// PWM channel divider settings: bit-serial divider
// Restoring divider producing one quotient bit per cycle. The dividend
// arrives aligned to the top of the word; the step count sets the width.
// ----------------------------------------------------------------------------
module pwmcds_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pwmcds_pkg::div_cmd_t             cmd,
    input  logic [pwmcds_pkg::DIV_W-1:0]     dividend,
    input  logic [pwmcds_pkg::DIVISOR_W-1:0] divisor,
    output logic [pwmcds_pkg::DIV_W-1:0]     quotient,
    output logic                             done
);

    logic [pwmcds_pkg::DIVISOR_W-1:0] rem_reg;
    logic [pwmcds_pkg::DIVISOR_W-1:0] dvs_reg;
    logic [pwmcds_pkg::DIV_W-1:0]     quo_reg;
    logic [pwmcds_pkg::STEP_W-1:0]    cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [pwmcds_pkg::DIVISOR_W:0]   trial;
    logic [pwmcds_pkg::DIVISOR_W:0]   diff;
    logic                             fits;
    logic [pwmcds_pkg::DIVISOR_W-1:0] rem_next;
    logic [pwmcds_pkg::DIV_W-1:0]     quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[pwmcds_pkg::DIV_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[pwmcds_pkg::DIVISOR_W-1:0]
                        : trial[pwmcds_pkg::DIVISOR_W-1:0];
        quo_next = {quo_reg[pwmcds_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            quo_reg  <= dividend;
            cnt_reg  <= cmd.steps;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == pwmcds_pkg::STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> design/pwm_channel_divider_settings_core.sv
// ----------------------------------------------------------------------------
// PWM channel divider settings core
// Apply: when the dividers are derived, the word runs through three divisions
// (frequency, base division, duty scaling) with a normalize stage between;
// rejected, disabled or out-of-range words answer without using the divider.
// Read back: three divisions for a running channel (frequency, period, high
// time); a disabled one answers without using the divider. One word at a
// time, paced by the single bit-serial divider; the receiver cannot stall the
// core. Reset clears every channel's fields to zero (disabled).
// ----------------------------------------------------------------------------
module pwm_channel_divider_settings_core #(
    parameter int CHANNELS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [1:0]  channel,
    input  logic [31:0] pwm_period_ns,
    input  logic [31:0] duty_ns,
    input  logic        enable,
    input  logic        inverted_polarity,
    output logic        done,
    output logic [1:0]  status,
    output logic        running,
    output logic [29:0] period_out_ns,
    output logic [36:0] duty_out_ns,
    output logic [7:0]  out_div_value,
    output logic [7:0]  duty_count_value,
    output logic [3:0]  src_div_value
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIV_W = pwmcds_pkg::DIV_W;

    // The sequencer walks one item through the shared divider. Apply goes
    // period -> frequency -> base division -> normalize -> duty scaling;
    // read back goes divider fields -> frequency -> period -> high time.
    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY_F,
        S_APPLY_D,
        S_SRC,
        S_MUL,
        S_APPLY_Q,
        S_RB_F,
        S_RB_P,
        S_RB_MUL,
        S_RB_DUTY
    } state_t;

    // Per-channel fields. These are tiny and reset to zero, so they are flops.
    logic [7:0] od_store_reg [CHANNELS];
    logic [7:0] dc_store_reg [CHANNELS];
    logic [3:0] sd_store_reg [CHANNELS];

    state_t      state_reg, state_next;
    logic [1:0]  ch_reg, ch_next;
    logic [31:0] period_reg, period_next;
    logic [31:0] duty_reg, duty_next;
    logic [7:0]  od_reg, od_next;
    logic [7:0]  dc_reg, dc_next;
    logic [3:0]  sd_reg, sd_next;
    logic [15:0] x_reg, x_next;
    logic [23:0] y_reg, y_next;
    logic [29:0] p_reg, p_next;

    logic        done_reg, done_next;
    logic [1:0]  status_reg, status_next;
    logic        running_reg, running_next;
    logic [29:0] pout_reg, pout_next;
    logic [36:0] dout_reg, dout_next;
    logic [7:0]  odv_reg, odv_next;
    logic [7:0]  dcv_reg, dcv_next;
    logic [3:0]  sdv_reg, sdv_next;

    // Store write port.
    logic            wr_en;
    logic [CH_W-1:0] wr_idx;
    logic [7:0]      wr_od;
    logic [7:0]      wr_dc;
    logic [3:0]      wr_sd;

    // Shared divider.
    pwmcds_pkg::div_cmd_t                    div_cmd;
    logic [DIV_W-1:0]                        div_dividend;
    logic [pwmcds_pkg::DIVISOR_W-1:0]        div_divisor;
    logic [DIV_W-1:0]                        div_quotient;
    logic                                    div_done;

    logic [CH_W-1:0] in_idx;
    logic            in_valid;
    logic [7:0]      in_od;
    logic [7:0]      in_dc;
    logic [3:0]      in_sd;
    logic            ch_valid;

    assign in_idx   = CH_W'(channel);
    assign in_valid = (32'(channel) < CHANNELS);
    assign in_od    = od_store_reg[in_idx];
    assign in_dc    = dc_store_reg[in_idx];
    assign in_sd    = sd_store_reg[in_idx];
    assign ch_valid = (32'(ch_reg) < CHANNELS);

    pwmcds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    always_comb
    begin
        logic [31:0] f_min;
        logic [24:0] rb_d;
        logic [24:0] rb_f;
        logic [30:0] p_num;
        logic [8:0]  o_plus;
        logic [8:0]  q_clamp;
        logic [23:0] y_dec;

        state_next   = state_reg;
        ch_next      = ch_reg;
        period_next  = period_reg;
        duty_next    = duty_reg;
        od_next      = od_reg;
        dc_next      = dc_reg;
        sd_next      = sd_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        p_next       = p_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        running_next = running_reg;
        pout_next    = pout_reg;
        dout_next    = dout_reg;
        odv_next     = odv_reg;
        dcv_next     = dcv_reg;
        sdv_next     = sdv_reg;

        wr_en  = 1'b0;
        wr_idx = in_idx;
        wr_od  = '0;
        wr_dc  = '0;
        wr_sd  = '0;

        div_cmd      = '0;
        div_dividend = '0;
        div_divisor  = '0;

        f_min   = (div_quotient[31:0] == 32'd0) ? 32'd1 : div_quotient[31:0];
        rb_d    = 25'({1'b0, in_od} + 9'd1) << ({1'b0, in_sd} + 5'd1);
        rb_f    = (div_quotient[24:0] == 25'd0) ? 25'd1 : div_quotient[24:0];
        p_num   = {1'b0, pwmcds_pkg::NS_PER_S} + 31'(rb_f) - 31'd1;
        o_plus  = {1'b0, od_reg} + 9'd1;
        y_dec   = y_reg - 24'd1;
        q_clamp = 9'd1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ch_next      = channel;
                    period_next  = pwm_period_ns;
                    duty_next    = duty_ns;
                    status_next  = pwmcds_pkg::STATUS_OK;
                    running_next = 1'b0;
                    pout_next    = '0;
                    dout_next    = '0;
                    odv_next     = in_valid ? in_od : 8'd0;
                    dcv_next     = in_valid ? in_dc : 8'd0;
                    sdv_next     = in_valid ? in_sd : 4'd0;
                    if (op == pwmcds_pkg::OP_APPLY)
                    begin
                        priority if (inverted_polarity)
                        begin
                            status_next = pwmcds_pkg::STATUS_INV_POL;
                            done_next   = 1'b1;
                        end
                        else if (enable && duty_ns != 32'd0 && pwm_period_ns == 32'd0)
                        begin
                            status_next = pwmcds_pkg::STATUS_ZERO_PER;
                            done_next   = 1'b1;
                        end
                        else if (!in_valid)
                        begin
                            done_next = 1'b1;
                        end
                        else if (!enable || duty_ns == 32'd0)
                        begin
                            // Channel off: clear all three fields.
                            wr_en     = 1'b1;
                            odv_next  = '0;
                            dcv_next  = '0;
                            sdv_next  = '0;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            div_cmd.start = 1'b1;
                            div_cmd.steps = pwmcds_pkg::STEP_W'(pwmcds_pkg::F_STEPS);
                            div_dividend  = DIV_W'(pwmcds_pkg::NS_PER_S)
                                            << (DIV_W - pwmcds_pkg::F_STEPS);
                            div_divisor   = pwm_period_ns;
                            state_next    = S_APPLY_F;
                        end
                    end
                    else
                    begin
                        if (!in_valid || in_od == 8'd0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            od_next       = in_od;
                            dc_next       = in_dc;
                            sd_next       = in_sd;
                            div_cmd.start = 1'b1;
                            div_cmd.steps = pwmcds_pkg::STEP_W'(pwmcds_pkg::D_STEPS);
                            div_dividend  = DIV_W'(pwmcds_pkg::BASE_HZ)
                                            << (DIV_W - pwmcds_pkg::D_STEPS);
                            div_divisor   = 32'(rb_d);
                            state_next    = S_RB_F;
                        end
                    end
                end
            end

            S_APPLY_F:
            begin
                if (div_done)
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.steps = pwmcds_pkg::STEP_W'(pwmcds_pkg::D_STEPS);
                    div_dividend  = DIV_W'(pwmcds_pkg::BASE_HZ)
                                    << (DIV_W - pwmcds_pkg::D_STEPS);
                    div_divisor   = f_min;
                    state_next    = S_APPLY_D;
                end
            end

            S_APPLY_D:
            begin
                if (div_done)
                begin
                    // x tracks d >> (s + 9) and y tracks d >> (s + 1).
                    x_next     = 16'(div_quotient[24:0] >> (pwmcds_pkg::SRC_MSB_OFFSET + 1));
                    y_next     = div_quotient[24:1];
                    sd_next    = '0;
                    state_next = S_SRC;
                end
            end

            S_SRC:
            begin
                if (sd_reg != pwmcds_pkg::SRC_DIV_MAX && x_reg != 16'd0)
                begin
                    x_next  = x_reg >> 1;
                    y_next  = y_reg >> 1;
                    sd_next = sd_reg + 4'd1;
                end
                else
                begin
                    priority if (y_reg == 24'd0)
                        od_next = '0;
                    else if (y_dec > 24'(pwmcds_pkg::OUT_DIV_MAX))
                        od_next = pwmcds_pkg::OUT_DIV_MAX;
                    else
                        od_next = y_dec[7:0];
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                div_cmd.start = 1'b1;
                div_cmd.steps = pwmcds_pkg::STEP_W'(pwmcds_pkg::Q_STEPS);
                div_dividend  = DIV_W'(duty_reg * 41'(o_plus))
                                << (DIV_W - pwmcds_pkg::Q_STEPS);
                div_divisor   = period_reg;
                state_next    = S_APPLY_Q;
            end

            S_APPLY_Q:
            begin
                if (div_done)
                begin
                    priority if (div_quotient == '0)
                        q_clamp = 9'd1;
                    else if (div_quotient > DIV_W'(o_plus))
                        q_clamp = o_plus;
                    else
                        q_clamp = div_quotient[8:0];
                    wr_en      = 1'b1;
                    wr_idx     = CH_W'(ch_reg);
                    wr_od      = od_reg;
                    wr_dc      = 8'(q_clamp - 9'd1);
                    wr_sd      = sd_reg;
                    odv_next   = od_reg;
                    dcv_next   = 8'(q_clamp - 9'd1);
                    sdv_next   = sd_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RB_F:
            begin
                if (div_done)
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.steps = pwmcds_pkg::STEP_W'(pwmcds_pkg::P_STEPS);
                    div_dividend  = DIV_W'(p_num) << (DIV_W - pwmcds_pkg::P_STEPS);
                    div_divisor   = 32'(rb_f);
                    state_next    = S_RB_P;
                end
            end

            S_RB_P:
            begin
                if (div_done)
                begin
                    p_next     = div_quotient[29:0];
                    state_next = S_RB_MUL;
                end
            end

            S_RB_MUL:
            begin
                // High time rounds up: (p * (cd + 1) + ocd) / (ocd + 1).
                div_cmd.start = 1'b1;
                div_cmd.steps = pwmcds_pkg::STEP_W'(pwmcds_pkg::DUTY_STEPS);
                div_dividend  = (DIV_W'(p_reg) * DIV_W'({1'b0, dc_reg} + 9'd1)
                                 + DIV_W'(od_reg))
                                << (DIV_W - pwmcds_pkg::DUTY_STEPS);
                div_divisor   = 32'(o_plus);
                state_next    = S_RB_DUTY;
            end

            S_RB_DUTY:
            begin
                if (div_done)
                begin
                    running_next = 1'b1;
                    pout_next    = p_reg;
                    dout_next    = div_quotient[36:0];
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ch_reg      <= '0;
            period_reg  <= '0;
            duty_reg    <= '0;
            od_reg      <= '0;
            dc_reg      <= '0;
            sd_reg      <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            p_reg       <= '0;
            done_reg    <= 1'b0;
            status_reg  <= '0;
            running_reg <= 1'b0;
            pout_reg    <= '0;
            dout_reg    <= '0;
            odv_reg     <= '0;
            dcv_reg     <= '0;
            sdv_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            period_reg  <= period_next;
            duty_reg    <= duty_next;
            od_reg      <= od_next;
            dc_reg      <= dc_next;
            sd_reg      <= sd_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            p_reg       <= p_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            running_reg <= running_next;
            pout_reg    <= pout_next;
            dout_reg    <= dout_next;
            odv_reg     <= odv_next;
            dcv_reg     <= dcv_next;
            sdv_reg     <= sdv_next;
        end
    end

    // Channel field store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                od_store_reg[i] <= '0;
                dc_store_reg[i] <= '0;
                sd_store_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            od_store_reg[wr_idx] <= wr_od;
            dc_store_reg[wr_idx] <= wr_dc;
            sd_store_reg[wr_idx] <= wr_sd;
        end
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign running          = running_reg;
    assign period_out_ns    = pout_reg;
    assign duty_out_ns      = dout_reg;
    assign out_div_value    = odv_reg;
    assign duty_count_value = dcv_reg;
    assign src_div_value    = sdv_reg;

    // An accepted word either answers on the next cycle or keeps the core busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted word neither answered nor started");

    // Leaving the busy phase always delivers the word's result.
    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy ended without a result strobe");

    // A running read back always comes from a nonzero output divider.
    a_running_div: assert property (@(posedge clk) disable iff (!rst_n)
        (done && running) |-> (out_div_value != 8'd0 && status == pwmcds_pkg::STATUS_OK))
        else $error("running reported with disabled divider or bad status");

    // The write port is only used by the sequencer's terminal steps.
    a_write_ch_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg != S_IDLE) |-> (state_reg == S_APPLY_Q && ch_valid))
        else $error("store written outside an apply completion");

endmodule
